// File: hdl/skvt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted key/value table.
// No dependencies; the top level and the testbench import this package.
package skvt_pkg;

    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 64;
    localparam int MAX_RESULTS = 64;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

    localparam int POS_W = 6;
    localparam int ENT_W = 7;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DROP   = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [63:0] value;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic [63:0]      found_key;
        logic [63:0]      found_value;
        logic [ENT_W-1:0] entries;
        logic             last;
    } rsp_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_CMP,
        S_ADD_WR,
        S_SCAN,
        S_DRP_SH,
        S_LIST,
        S_RESP
    } state_t;

endpackage

// File: hdl/sorted_key_value_table_core.sv
`timescale 1ns / 1ps
// Sorted key/value table, top level: sequencer, entry count and result register.
// Depends on skvt_pkg and skvt_ram.
//
// The table holds up to DEPTH (64) key/value pairs in ascending unsigned key
// order in one RAM, one pair per word, and a single read/compare/write path
// walks it one entry per cycle. A request beat is taken only while the block
// is idle; req_stall is high for the whole time an op runs. Add reads from
// the tail and moves every larger entry up one slot. Drop and search scan
// from slot 0, and a drop then moves every later entry down, one per cycle.
// List sends one response beat per entry, one per cycle while rsp_stall is
// low, capped at 64 beats; the final beat carries last. Every other op sends
// exactly one beat, with last set. Add to a full table returns status full
// and stores nothing; drop or search of a missing key returns not found;
// list of an empty table returns status empty. The response register lets a
// new request be taken while the previous beat still waits. RAM contents are
// not cleared at reset; only data read from slots below the entry count is
// ever used.
module sorted_key_value_table_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  skvt_pkg::req_beat_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output skvt_pkg::rsp_beat_t rsp
);

    import skvt_pkg::*;

    // control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [1:0]            op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    rsp_beat_t             res_reg, res_next;
    rsp_beat_t             out_reg, out_next;

    // RAM port
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [KEY_BITS-1:0]   in_key;
    logic                  accept, can_load;
    logic [SUM_W-1:0]      idx_p1, idx_p2, cnt_w;
    logic [CNT_W-1:0]      list_n;

    skvt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_key = ram_rdata[ENTRY_W-1 -: KEY_BITS];
    assign rd_val = ram_rdata[VALUE_BITS-1:0];
    assign in_key = req.key[KEY_BITS-1:0];

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    // output register is free, or its beat leaves this cycle
    assign can_load  = !out_valid_reg || !rsp_stall;

    assign idx_p1 = SUM_W'(idx_reg) + SUM_W'(1);
    assign idx_p2 = SUM_W'(idx_reg) + SUM_W'(2);
    assign cnt_w  = SUM_W'(count_reg);
    assign list_n = (count_reg > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        op_reg  <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        idx_next       = idx_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.op;
                    key_next = in_key;
                    val_next = req.value;
                    res_next = '0;
                    idx_next = '0;
                    unique case (req.op)
                        OP_ADD:
                        begin
                            if (cnt_w >= SUM_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_ADD_WR;
                            end
                            else
                            begin
                                // start at the tail: compare entry count-1
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(cnt_w - SUM_W'(1));
                                idx_next   = IDX_W'(count_reg);
                                state_next = S_ADD_CMP;
                            end
                        end
                        OP_DROP, OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NOTFOUND;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD_CMP:
            begin
                // rdata holds entry idx-1
                if (rd_key > key_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - IDX_W'(1);
                    if (idx_reg == IDX_W'(1))
                    begin
                        state_next = S_ADD_WR;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    state_next = S_ADD_WR;
                end
            end

            S_ADD_WR:
            begin
                ram_we               = 1'b1;
                ram_waddr            = idx_reg;
                ram_wdata            = {key_reg, val_reg};
                count_next           = count_reg + CNT_W'(1);
                res_next.status      = ST_OK;
                res_next.position    = POS_W'(idx_reg);
                res_next.found_key   = 64'(key_reg);
                res_next.found_value = 64'(val_reg);
                state_next           = S_RESP;
            end

            S_SCAN:
            begin
                // rdata holds entry idx; fetch idx+1 in case it is needed
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(idx_p1);
                if (rd_key == key_reg)
                begin
                    res_next.status      = ST_OK;
                    res_next.position    = POS_W'(idx_reg);
                    res_next.found_key   = 64'(rd_key);
                    res_next.found_value = 64'(rd_val);
                    if (op_reg == OP_DROP)
                    begin
                        if (idx_p1 < cnt_w)
                        begin
                            state_next = S_DRP_SH;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_RESP;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (idx_p1 == cnt_w)
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    idx_next = IDX_W'(idx_p1);
                end
            end

            S_DRP_SH:
            begin
                // rdata holds entry idx+1; move it down to idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(idx_p2);
                idx_next  = IDX_W'(idx_p1);
                if (idx_p2 >= cnt_w)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end

            S_LIST:
            begin
                if (can_load)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = ST_OK;
                    out_next.position    = POS_W'(idx_reg);
                    out_next.found_key   = 64'(rd_key);
                    out_next.found_value = 64'(rd_val);
                    out_next.entries     = ENT_W'(count_reg);
                    out_next.last        = (idx_p1 == SUM_W'(list_n));
                    if (idx_p1 == SUM_W'(list_n))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = IDX_W'(idx_p1);
                        idx_next  = IDX_W'(idx_p1);
                    end
                end
            end

            S_RESP:
            begin
                if (can_load)
                begin
                    out_valid_next   = 1'b1;
                    out_next         = res_reg;
                    out_next.entries = ENT_W'(count_reg);
                    out_next.last    = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // table never holds more than DEPTH entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(count_reg) <= SUM_W'(DEPTH))
        else $error("entry count above depth");

    // a new response beat only comes from the list or single-result states
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_LIST || $past(state_reg) == S_RESP))
        else $error("response loaded from wrong state");

    // insertion walk never runs below slot 1
    a_add_walk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD_CMP |-> (idx_reg != '0 && SUM_W'(idx_reg) <= cnt_w))
        else $error("insert walk out of range");

    // drop shift only moves entries that are held
    a_drop_shift: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRP_SH |-> idx_p1 < cnt_w)
        else $error("drop shift past entry count");

    // a beat leaving the response register while the table is empty is one result only
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_EMPTY) |-> rsp.last)
        else $error("empty-table response without last");

endmodule

// File: hdl/skvt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; read data holds while re is low.
module skvt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for sorted_key_value_table_core: directed and random request beats, with every
// response beat checked against a table model kept here. Depends on skvt_pkg and the core RTL.
module tb_top;
    import skvt_pkg::*;

    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    // Names packed first char high, zero padded.
    localparam logic [63:0] NAME_ABC = 64'h6162_6300_0000_0000;
    localparam logic [63:0] NAME_MID = 64'h6d69_6400_0000_0000;
    localparam logic [63:0] NAME_ZZZ = 64'h7a7a_7a00_0000_0000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_beat_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_beat_t rsp;

    sorted_key_value_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Table model: sorted keys and values, plus the response beats still owed.
    logic [63:0] key_tab [DEPTH];
    logic [63:0] val_tab [DEPTH];
    int unsigned tab_count;
    rsp_beat_t   rsp_due [$];
    logic [63:0] name_pool [8];

    int  errors;
    int  reqs_sent;
    int  lists_sent;
    int  beats_checked;
    int  peak_entries;
    bit  req_gaps;
    bit  stall_bursts;

    function automatic void owe_beat(logic [1:0] st, int unsigned pos, logic [63:0] k,
                                     logic [63:0] v, logic lst);
        rsp_beat_t b;
        b.status      = st;
        b.position    = pos[POS_W-1:0];
        b.found_key   = k;
        b.found_value = v;
        b.entries     = tab_count[ENT_W-1:0];
        b.last        = lst;
        rsp_due.push_back(b);
    endfunction

    // Apply one accepted request to the table and queue the beats it owes.
    function automatic void table_apply(req_beat_t b);
        logic [63:0] k;
        logic [63:0] kv;
        logic [63:0] vv;
        int unsigned pos;
        int unsigned n;
        bit          hit;
        k   = b.key & KEY_MASK;
        hit = 1'b0;
        pos = 0;
        case (b.op)
            OP_ADD:
            begin
                if (tab_count >= DEPTH)
                    owe_beat(ST_FULL, 0, '0, '0, 1'b1);
                else
                begin
                    // equal keys stay ahead of the new pair
                    pos = tab_count;
                    while (pos > 0 && key_tab[pos-1] > k)
                    begin
                        key_tab[pos] = key_tab[pos-1];
                        val_tab[pos] = val_tab[pos-1];
                        pos--;
                    end
                    key_tab[pos] = k;
                    val_tab[pos] = b.value;
                    tab_count++;
                    owe_beat(ST_OK, pos, k, b.value, 1'b1);
                end
            end
            OP_DROP, OP_SEARCH:
            begin
                for (int j = 0; j < tab_count; j++)
                begin
                    if (!hit && key_tab[j] == k)
                    begin
                        hit = 1'b1;
                        pos = j;
                    end
                end
                if (!hit)
                    owe_beat(ST_NOTFOUND, 0, '0, '0, 1'b1);
                else
                begin
                    kv = key_tab[pos];
                    vv = val_tab[pos];
                    if (b.op == OP_DROP)
                    begin
                        for (int j = pos; j + 1 < tab_count; j++)
                        begin
                            key_tab[j] = key_tab[j+1];
                            val_tab[j] = val_tab[j+1];
                        end
                        tab_count--;
                    end
                    owe_beat(ST_OK, pos, kv, vv, 1'b1);
                end
            end
            default:
            begin
                n = (tab_count > MAX_RESULTS) ? MAX_RESULTS : tab_count;
                if (n == 0)
                    owe_beat(ST_EMPTY, 0, '0, '0, 1'b1);
                else
                    for (int j = 0; j < n; j++)
                        owe_beat(ST_OK, j, key_tab[j], val_tab[j], j + 1 == n);
            end
        endcase
    endfunction

    // One request beat: optional gap, then hold valid and payload until taken.
    // Valid is left high on return; the next call or end_requests moves it.
    task automatic send_req(logic [1:0] op, logic [63:0] key, logic [63:0] value);
        req_beat_t b;
        b.op    = op;
        b.key   = key;
        b.value = value;
        @(negedge clk);
        if (req_gaps && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        req       <= b;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        table_apply(b);
        reqs_sent++;
        if (op == OP_LIST)
            lists_sent++;
        if (tab_count > peak_entries)
            peak_entries = tab_count;
    endtask

    task automatic end_requests();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_name();
        logic [63:0] nm;
        int          len;
        nm  = '0;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            nm[63-8*i -: 8] = 8'($urandom_range(97, 122));
        return nm;
    endfunction

    // Mostly keys that can hit: pool names and keys already held.
    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30 && tab_count > 0)
            return key_tab[$urandom_range(0, tab_count - 1)];
        else if (r < 70)
            return name_pool[$urandom_range(0, 7)];
        else if (r < 90)
            return rand_name();
        else
            return {$urandom, $urandom};
    endfunction

    // Response checker: each taken beat against the oldest owed beat.
    function automatic void check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_beat_t owed;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (rsp_due.size() == 0)
            begin
                errors++;
                $display("%0t: response beat with none owed, expected nothing, actual %p",
                         $time, rsp);
            end
            else
            begin
                owed = rsp_due.pop_front();
                check_field("status", 64'(owed.status), 64'(rsp.status));
                check_field("position", 64'(owed.position), 64'(rsp.position));
                check_field("found_key", owed.found_key, rsp.found_key);
                check_field("found_value", owed.found_value, rsp.found_value);
                check_field("entries", 64'(owed.entries), 64'(rsp.entries));
                check_field("last", 64'(owed.last), 64'(rsp.last));
                beats_checked++;
            end
        end
    end

    // Receiver stalls in bursts of random length while enabled.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_bursts && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Empty table: list reports empty, lookups report not found.
    task automatic test_empty_table();
        send_req(OP_LIST, '0, '0);
        send_req(OP_SEARCH, NAME_MID, '0);
        send_req(OP_DROP, ALL_ONES, '0);
    endtask

    // Ordering at the key extremes, duplicate keys, first-match lookups, misses.
    task automatic test_order_and_duplicates();
        send_req(OP_ADD, NAME_MID, 64'h3100_0000_0000_0000);
        send_req(OP_ADD, ALL_ONES, ALL_ONES);
        send_req(OP_ADD, '0, '0);
        send_req(OP_ADD, NAME_MID, 64'h3200_0000_0000_0000);
        send_req(OP_ADD, NAME_ABC, 64'h3432_0000_0000_0000);
        send_req(OP_SEARCH, NAME_MID, ALL_ONES);
        send_req(OP_LIST, ALL_ONES, ALL_ONES);
        send_req(OP_DROP, NAME_MID, '0);
        send_req(OP_SEARCH, NAME_MID, '0);
        send_req(OP_DROP, NAME_ZZZ, '0);
        send_req(OP_SEARCH, ALL_ONES, '0);
        send_req(OP_DROP, '0, '0);
        send_req(OP_LIST, '0, '0);
    endtask

    // Random op mix; adds favored while the table is small, lists kept rare.
    task automatic test_random_mix(int n_items);
        int r;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40 || tab_count < 3)
                send_req(OP_ADD, pick_key(), {$urandom, $urandom});
            else if (r < 65)
                send_req(OP_DROP, pick_key(), {$urandom, $urandom});
            else if (r < 92)
                send_req(OP_SEARCH, pick_key(), {$urandom, $urandom});
            else
                send_req(OP_LIST, pick_key(), {$urandom, $urandom});
        end
    endtask

    // Fill to capacity, refuse further adds, list the full table, drain part of it.
    task automatic test_fill_to_capacity();
        while (tab_count < DEPTH)
            send_req(OP_ADD, pick_key(), {$urandom, $urandom});
        send_req(OP_ADD, ALL_ONES, ALL_ONES);
        send_req(OP_ADD, '0, {$urandom, $urandom});
        send_req(OP_LIST, '0, '0);
        send_req(OP_SEARCH, key_tab[DEPTH-1], '0);
        repeat (16)
            send_req(OP_DROP, pick_key(), '0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        tab_count    = 0;
        errors       = 0;
        reqs_sent    = 0;
        lists_sent   = 0;
        beats_checked = 0;
        peak_entries = 0;
        req_gaps     = 1'b1;
        stall_bursts = 1'b1;
        foreach (name_pool[i])
            name_pool[i] = rand_name();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_order_and_duplicates();
        test_random_mix(50);
        test_fill_to_capacity();

        // closing stretch runs without idling on either side
        req_gaps     = 1'b0;
        stall_bursts = 1'b0;
        test_random_mix(20);

        end_requests();
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("covered %0d requests (%0d lists) and %0d response beats", reqs_sent,
                 lists_sent, beats_checked);
        $display("table peaked at %0d of %0d entries, with full, empty and miss cases",
                 peak_entries, DEPTH);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("timeout with %0d response beats still owed", rsp_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
